// File: rtl/ppc_pkg.sv
package ppc_pkg;

    localparam int ADC_BITS    = 12;
    localparam int FRAC_BITS   = 12;
    localparam int RANGE_SLACK = 20;

    localparam int ONE_Q  = 1 << FRAC_BITS;
    localparam int OUT_W  = FRAC_BITS + 1;
    localparam int LIM_W  = 13;
    localparam int CFG_W  = 13;
    localparam int SPAN_W = ADC_BITS + 2;

    // shared divider: dividend = 2*mag*ONE + den, divisor = 2*den
    localparam int DIV_W     = ADC_BITS + FRAC_BITS + 2;
    localparam int DSR_W     = ADC_BITS + 1;
    localparam int QUO_W     = FRAC_BITS + 5;
    localparam int N_W       = QUO_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // exact integer forms of the threshold tests
    localparam int THR_HIGH_MAX  = ONE_Q / 10;
    localparam int AVG_LOW_MAX   = (ONE_Q - 1) / 20;
    localparam int BRAKE_LOW_MAX = (3 * ONE_Q - 1) / 2000;

    typedef enum logic [2:0] {
        CFG_ACC1_START,
        CFG_ACC1_END,
        CFG_ACC2_START,
        CFG_ACC2_END,
        CFG_BRAKE_START,
        CFG_BRAKE_END,
        CFG_DISAGREE_LIMIT,
        CFG_HARD_BRAKE_LEVEL
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RUN,
        S_STORE,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        SEL_ACC1,
        SEL_ACC2,
        SEL_BRAKE
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_init;
        logic     div_step;
        logic     store;
        logic     commit;
        t_div_sel sel;
    } t_cmd;

    typedef struct packed {
        logic [ADC_BITS-1:0] acc1_raw;
        logic [ADC_BITS-1:0] acc2_raw;
        logic [ADC_BITS-1:0] brake_raw;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] throttle;
        logic [OUT_W-1:0] brake_level;
        logic             implausible;
    } t_out;

endpackage

// File: rtl/ppc_ctrl.sv
module ppc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ppc_pkg::t_cmd o_cmd
);
    import ppc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

    t_state               r_state, n_state;
    t_div_sel             r_sel, n_sel;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_ACC1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.sel   = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = SEL_ACC1;
                    n_state    = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_RUN;
            end
            S_RUN: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                case (r_sel)
                    SEL_ACC1: begin
                        n_sel   = SEL_ACC2;
                        n_state = S_INIT;
                    end
                    SEL_ACC2: begin
                        n_sel   = SEL_BRAKE;
                        n_state = S_INIT;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_INIT && r_sel == SEL_ACC1))
        else $error("request accepted but divider sequence not started");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt != CNT_LAST) |=> (r_state == S_RUN))
        else $error("divider run left early");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");

endmodule

// File: rtl/ppc_datapath.sv
module ppc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [ppc_pkg::CFG_W-1:0] i_cfg_data,
    input  ppc_pkg::t_in              i_in,
    input  ppc_pkg::t_cmd             i_cmd,
    output ppc_pkg::t_out             o_out
);
    import ppc_pkg::*;

    localparam logic [SPAN_W-1:0] SLACK = SPAN_W'(RANGE_SLACK);
    localparam logic [OUT_W-1:0]  ONE_O = OUT_W'(ONE_Q);

    logic [ADC_BITS-1:0] r_acc1_start, r_acc1_end, r_acc2_start, r_acc2_end;
    logic [ADC_BITS-1:0] r_brake_start, r_brake_end;
    logic [LIM_W-1:0]    r_disagree_limit, r_hard_brake_level;

    logic [ADC_BITS-1:0] r_raw1, r_raw2, r_rawb;

    logic [DIV_W-1:0]     r_quo;
    logic [DSR_W-1:0]     r_rem;
    logic [DSR_W-1:0]     r_dsr;
    logic                 r_neg;

    logic signed [N_W-1:0] r_n1, r_n2;
    logic [OUT_W-1:0]      r_bq;

    logic                 r_fault, n_fault;
    logic [OUT_W-1:0]     r_last, n_thr;
    t_out                 r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc1_start       <= '0;
            r_acc1_end         <= '1;
            r_acc2_start       <= '0;
            r_acc2_end         <= '1;
            r_brake_start      <= '0;
            r_brake_end        <= '1;
            r_disagree_limit   <= LIM_W'(410);
            r_hard_brake_level <= LIM_W'(819);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_ACC1_START:       r_acc1_start       <= i_cfg_data[ADC_BITS-1:0];
                CFG_ACC1_END:         r_acc1_end         <= i_cfg_data[ADC_BITS-1:0];
                CFG_ACC2_START:       r_acc2_start       <= i_cfg_data[ADC_BITS-1:0];
                CFG_ACC2_END:         r_acc2_end         <= i_cfg_data[ADC_BITS-1:0];
                CFG_BRAKE_START:      r_brake_start      <= i_cfg_data[ADC_BITS-1:0];
                CFG_BRAKE_END:        r_brake_end        <= i_cfg_data[ADC_BITS-1:0];
                CFG_DISAGREE_LIMIT:   r_disagree_limit   <= i_cfg_data[LIM_W-1:0];
                CFG_HARD_BRAKE_LEVEL: r_hard_brake_level <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw1 <= i_in.acc1_raw;
            r_raw2 <= i_in.acc2_raw;
            r_rawb <= i_in.brake_raw;
        end
    end

    // accelerator operands
    logic [ADC_BITS:0] w_num1, w_num2, w_sel_num;
    logic [ADC_BITS:0] w_den1, w_den2;
    // brake operands, span turned around when reversed
    logic [ADC_BITS:0] w_bnum, w_bden, w_onum, w_oden;
    logic              w_brev;

    assign w_num1 = {1'b0, r_raw1} - {1'b0, r_acc1_start};
    assign w_num2 = {1'b0, r_raw2} - {1'b0, r_acc2_start};
    assign w_den1 = {1'b0, r_acc1_end} - {1'b0, r_acc1_start};
    assign w_den2 = {1'b0, r_acc2_end} - {1'b0, r_acc2_start};
    assign w_bnum = {1'b0, r_rawb} - {1'b0, r_brake_start};
    assign w_bden = {1'b0, r_brake_end} - {1'b0, r_brake_start};
    assign w_brev = w_bden[ADC_BITS];
    assign w_onum = w_brev ? -w_bnum : w_bnum;
    assign w_oden = w_brev ? -w_bden : w_bden;

    logic [ADC_BITS-1:0] w_mag, w_den;
    logic                w_neg;

    always_comb begin
        case (i_cmd.sel)
            SEL_ACC1: begin
                w_sel_num = w_num1;
                w_den     = w_den1[ADC_BITS-1:0];
                w_neg     = w_num1[ADC_BITS];
            end
            SEL_ACC2: begin
                w_sel_num = w_num2;
                w_den     = w_den2[ADC_BITS-1:0];
                w_neg     = w_num2[ADC_BITS];
            end
            default: begin
                w_sel_num = w_onum;
                w_den     = w_oden[ADC_BITS-1:0];
                w_neg     = 1'b0;
            end
        endcase
        w_mag = w_neg ? ADC_BITS'(-w_sel_num) : w_sel_num[ADC_BITS-1:0];
    end

    logic [DIV_W-1:0] w_dividend;
    assign w_dividend = (DIV_W'(w_mag) << (FRAC_BITS + 1)) + DIV_W'(w_den);

    // restoring divider, one quotient bit per step
    logic [DSR_W:0] w_rem_sh, w_diff;
    logic           w_ge;

    assign w_rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dsr};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= w_dividend;
            r_rem <= '0;
            r_dsr <= {w_den, 1'b0};
            r_neg <= w_neg;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DSR_W-1:0] : w_rem_sh[DSR_W-1:0];
        end
    end

    logic signed [N_W-1:0] w_nq;
    assign w_nq = r_neg ? -$signed({1'b0, r_quo[QUO_W-1:0]})
                        :  $signed({1'b0, r_quo[QUO_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            case (i_cmd.sel)
                SEL_ACC1: r_n1 <= w_nq;
                SEL_ACC2: r_n2 <= w_nq;
                default:  r_bq <= r_quo[OUT_W-1:0];
            endcase
        end
    end

    // range checks
    logic w_ok1, w_ok2;
    assign w_ok1 = (r_acc1_end > r_acc1_start)
                && (SPAN_W'(r_raw1) <= SPAN_W'(r_acc1_end) + SLACK)
                && (SPAN_W'(r_raw1) + SLACK >= SPAN_W'(r_acc1_start));
    assign w_ok2 = (r_acc2_end > r_acc2_start)
                && (SPAN_W'(r_raw2) <= SPAN_W'(r_acc2_end) + SLACK)
                && (SPAN_W'(r_raw2) + SLACK >= SPAN_W'(r_acc2_start));

    // brake level
    logic [OUT_W-1:0] w_brake;
    always_comb begin
        if (w_bden == '0) begin
            w_brake = (!w_bnum[ADC_BITS] && w_bnum != '0) ? ONE_O : '0;
        end else if (w_onum[ADC_BITS] || w_onum == '0) begin
            w_brake = '0;
        end else if (w_onum >= w_oden) begin
            w_brake = ONE_O;
        end else begin
            w_brake = r_bq;
        end
    end

    // disagreement and average
    logic signed [N_W:0] w_diff_n, w_abs_n, w_sum, w_half;
    logic [OUT_W-1:0]    w_avg;
    logic                w_disagree, w_hard, w_clear;

    assign w_diff_n   = (N_W+1)'(r_n1) - (N_W+1)'(r_n2);
    assign w_abs_n    = w_diff_n[N_W] ? -w_diff_n : w_diff_n;
    assign w_disagree = (w_abs_n > $signed({{(N_W+1-LIM_W){1'b0}}, r_disagree_limit}));
    assign w_sum      = (N_W+1)'(r_n1) + (N_W+1)'(r_n2);
    assign w_half     = w_sum >>> 1;

    always_comb begin
        if (w_sum[N_W]) begin
            w_avg = '0;
        end else if (w_half > (N_W+1)'(ONE_Q)) begin
            w_avg = ONE_O;
        end else begin
            w_avg = w_half[OUT_W-1:0];
        end
    end

    assign w_hard  = (w_brake > r_hard_brake_level) && (r_last > OUT_W'(THR_HIGH_MAX));
    assign w_clear = (w_avg <= OUT_W'(AVG_LOW_MAX)) && (w_brake <= OUT_W'(BRAKE_LOW_MAX));

    always_comb begin
        n_fault = r_fault;
        n_thr   = '0;
        if (!w_ok1 || !w_ok2 || w_disagree) begin
            n_fault = 1'b1;
        end else begin
            n_fault = r_fault || w_hard;
            if (n_fault && w_clear) begin
                n_fault = 1'b0;
            end
            n_thr = n_fault ? '0 : w_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= 1'b0;
            r_last  <= '0;
        end else if (i_cmd.commit) begin
            r_fault <= n_fault;
            r_last  <= n_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.throttle    <= n_thr;
            r_out.brake_level <= w_brake;
            r_out.implausible <= n_fault;
        end
    end

    assign o_out = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> (r_last == '0))
        else $error("throttle held nonzero under latched fault");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last <= ONE_O)
        else $error("throttle beyond full scale");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_out.throttle == r_last && r_out.implausible == r_fault))
        else $error("result register out of step with latched state");

endmodule

// File: rtl/pedal_plausibility_checker.sv
// Accelerator pedal plausibility checker. Each request carries two accelerator
// sensor samples and one brake sample; each yields exactly one result with the
// Q1.12 throttle command (zero while the fault is latched), the clamped Q1.12
// brake level and the fault flag. The result register is loaded once all three
// normalizations and the checks are done, and the block is ready for the next
// request once the result is registered; it takes no new sample set while one is
// in flight, and it waits while the output side stalls. The pace is set by the
// single shared restoring divider: three normalizations run back to back on it,
// each a setup step, 26 one-bit steps and a store step, followed by the checks
// and the result register. Configuration writes take effect at once and must
// only be issued while the block is idle.
module pedal_plausibility_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [ppc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  ppc_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output ppc_pkg::t_out             o_out
);
    import ppc_pkg::*;

    t_cmd w_cmd;

    ppc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    ppc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_out      (o_out)
    );

endmodule
